// ===== sv/msic_pkg.sv =====
// Package: shared types and codes for the inversion-counting sorter.
package msic_pkg;

  // Fixed field widths
  localparam int VAL_W    = 32;
  localparam int INV_W    = 11;
  // Per-item displacement count; holds up to the largest supported capacity
  localparam int HOP_W    = 7;
  localparam int CAPACITY_DEFAULT = 64;

  // Token modes while an item walks the cell row
  localparam logic [1:0] MODE_SEARCH = 2'd0;  // looking for its slot
  localparam logic [1:0] MODE_SHIFT  = 2'd1;  // displaced value moving right
  localparam logic [1:0] MODE_DONE   = 2'd2;  // value placed, count still traveling

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic [INV_W-1:0]        inversions;
    logic                    overflow;
    logic                    last_out;
  } out_t;

  // Token handed from one cell to the next
  typedef struct packed {
    logic                    valid;
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] value;
    logic [HOP_W-1:0]        hops;
  } tok_t;

  // Value held by one cell
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
  } slot_t;

endpackage

// ===== sv/msic_cell.sv =====
// One cell of the sorting row: holds one value and passes a token right.
module msic_cell (
  input  logic          clk,
  input  logic          rst,
  input  msic_pkg::tok_t  tin,
  input  logic          shift_en,
  input  msic_pkg::slot_t right,
  output msic_pkg::tok_t  tout,
  output msic_pkg::slot_t hold
);
  import msic_pkg::*;

  slot_t hold_next;
  tok_t  tok_next;

  // Insert, displace or pass; drain shifts the row left
  always_comb begin
    hold_next = hold;
    tok_next  = tin;
    if (shift_en) begin
      hold_next      = right;
      tok_next.valid = 1'b0;
    end else if (tin.valid) begin
      case (tin.mode)
        MODE_SEARCH: begin
          if (!hold.valid) begin
            hold_next     = '{valid: 1'b1, value: tin.value};
            tok_next.mode = MODE_DONE;
          end else if (tin.value < hold.value) begin
            // strictly smaller: take this slot, push the held value on
            hold_next      = '{valid: 1'b1, value: tin.value};
            tok_next.mode  = MODE_SHIFT;
            tok_next.value = hold.value;
            tok_next.hops  = tin.hops + HOP_W'(1);
          end
        end
        MODE_SHIFT: begin
          hold_next = '{valid: 1'b1, value: tin.value};
          if (!hold.valid) begin
            tok_next.mode = MODE_DONE;
          end else begin
            tok_next.value = hold.value;
            tok_next.hops  = tin.hops + HOP_W'(1);
          end
        end
        default: begin
          // placed token just carries its count to the end of the row
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
      tout <= '0;
    end else begin
      hold <= hold_next;
      tout <= tok_next;
    end
  end

endmodule

// ===== sv/merge_sort_inversion_counter_top.sv =====
// Top level: inversion-counting sorter built from a row of insertion cells.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   item     | item_valid / item_stall    | value, last
//   result   | result_valid / result_stall| sorted_value, inversions, overflow,
//            |                            | last_out
//
// Loads one item per unstalled cycle; each item walks the row one cell a cycle.
// After the last item the row settles as a flush count runs down from CAPACITY,
// then the batch leaves cell 0 one value per unstalled cycle, n results in all.
// item_stall is high from the last item until the final result is taken.
// result_stall freezes the row and the result; reset empties the row.
module merge_sort_inversion_counter_top #(
  parameter int CAPACITY = msic_pkg::CAPACITY_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  msic_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output msic_pkg::out_t result
);
  import msic_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]       state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    flush;
  logic [INV_W-1:0] total;
  logic             overflow_seen;

  tok_t  toks [0:CAPACITY];
  slot_t slots [0:CAPACITY];

  logic item_take;
  logic result_take;
  logic room;

  assign item_stall   = (state != ST_LOAD);
  assign item_take    = item_valid && !item_stall;
  assign result_valid = (state == ST_EMIT);
  assign result_take  = result_valid && !result_stall;
  assign room         = (count < CW'(CAPACITY));

  // New item enters the first cell as a searching token
  assign toks[0] = '{valid: item_take && room, mode: MODE_SEARCH, value: item.value,
                     hops: '0};
  assign slots[CAPACITY] = '0;

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    msic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tin      (toks[g]),
      .shift_en (result_take),
      .right    (slots[g+1]),
      .tout     (toks[g+1]),
      .hold     (slots[g])
    );
  end

  // Sorted value comes straight from the first cell
  assign result.sorted_value = slots[0].value;
  assign result.inversions   = total;
  assign result.overflow     = overflow_seen;
  assign result.last_out     = (count == CW'(1));

  // Control: load, settle, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      flush         <= '0;
      total         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      // counts arrive at the end of the row
      if (toks[CAPACITY].valid) begin
        total <= total + INV_W'(toks[CAPACITY].hops);
      end
      unique case (state)
        ST_LOAD: begin
          if (item_take) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (item.last) begin
              flush <= CW'(CAPACITY);
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (flush == '0) begin
            state <= ST_EMIT;
          end else begin
            flush <= flush - CW'(1);
          end
        end
        ST_EMIT: begin
          if (result_take) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              total         <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== sv/msic_checker.sv =====
// Checker: port-level properties of the sorter, bound to the top level.
module msic_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_stall,
  input msic_pkg::in_t  item,
  input logic           result_valid,
  input logic           result_stall,
  input msic_pkg::out_t result
);
  import msic_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // No item is taken while results go out
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item accepted during emission");

  // The closing item shuts the input
  a_close: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.last |=> item_stall && !result_valid)
    else $error("batch did not close");

  // Emission ends with the final value
  a_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.last_out |=> !result_valid && !item_stall)
    else $error("emission ran past final value");

endmodule

bind merge_sort_inversion_counter_top msic_checker u_msic_checker (.*);

// ===== tb/sv/sorted_batch_checker.sv =====
// Checker: predicts each sorted batch with its inversion total and compares the results.
module sorted_batch_checker #(
  parameter int CAPACITY = msic_pkg::CAPACITY_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_stall,
  input  msic_pkg::in_t  item,
  input  logic           result_valid,
  input  logic           result_stall,
  input  msic_pkg::out_t result,
  output int             errors,
  output int             pending,
  output int             results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import msic_pkg::*;

  // Batch being collected and the sorted values still owed by the block
  logic signed [VAL_W-1:0] batch_vals[$];
  logic                    batch_overflow = 1'b0;
  out_t                    sorted_q[$];
  int                      mismatch_count = 0;
  int                      result_count = 0;

  // Stable insertion sort; every shift past a larger value is one inversion
  function automatic void close_batch();
    logic signed [VAL_W-1:0] vals[$];
    logic signed [VAL_W-1:0] key;
    int                      inv;
    int                      j;
    out_t                    r;
    vals = batch_vals;
    inv = 0;
    for (int i = 1; i < vals.size(); i++) begin
      key = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > key) begin
        vals[j + 1] = vals[j];
        j--;
        inv++;
      end
      vals[j + 1] = key;
    end
    foreach (vals[k]) begin
      r.sorted_value = vals[k];
      r.inversions   = inv[INV_W-1:0];
      r.overflow     = batch_overflow;
      r.last_out     = (k == vals.size() - 1);
      sorted_q = {sorted_q, r};
    end
    batch_vals.delete();
    batch_overflow = 1'b0;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      // Collect items; drop those past capacity and flag it
      if (item_valid && !item_stall) begin
        if (batch_vals.size() < CAPACITY) batch_vals = {batch_vals, item.value};
        else batch_overflow = 1'b1;
        if (item.last) close_batch();
      end
      // Compare each result with the oldest owed value
      if (result_valid && !result_stall) begin
        result_count++;
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %0d inv %0d ovf %0b last %0b",
                   $time, result.sorted_value, result.inversions, result.overflow,
                   result.last_out);
          mismatch_count++;
        end else begin
          want = sorted_q.pop_front();
          if (result.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                     $time, want.sorted_value, result.sorted_value);
            mismatch_count++;
          end
          if (result.inversions !== want.inversions) begin
            $display("%0t: inversions mismatch: expected %0d, got %0d",
                     $time, want.inversions, result.inversions);
            mismatch_count++;
          end
          if (result.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, want.overflow, result.overflow);
            mismatch_count++;
          end
          if (result.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch: expected %0b, got %0b",
                     $time, want.last_out, result.last_out);
            mismatch_count++;
          end
        end
      end
    end
    errors       <= mismatch_count;
    pending      <= sorted_q.size();
    results_seen <= result_count;
  end

endmodule

// ===== tb/sv/merge_sort_inversion_counter_top_tb.sv =====
// Testbench top: batch stimulus, result back-pressure and verdict for the sorter.
module merge_sort_inversion_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msic_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEFAULT;
  localparam int ITEM_TARGET  = 500;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

  // Batch content styles
  localparam int GEN_RANDOM  = 0;
  localparam int GEN_SMALL   = 1;
  localparam int GEN_RISING  = 2;
  localparam int GEN_FALLING = 3;
  localparam int GEN_EXTREME = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t  item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;
  int   errors;
  int   pending;
  int   results_seen;
  int   items_sent = 0;
  int   idle_cycles = 0;

  logic signed [VAL_W-1:0] batch_q[$];

  always #5 clk = ~clk;

  merge_sort_inversion_counter_top #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  sorted_batch_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Value for position k of a batch in the given content style
  function automatic logic signed [VAL_W-1:0] gen_value(input int mode, input int k);
    case (mode)
      GEN_RANDOM:  return $urandom;
      GEN_SMALL:   return $signed($urandom_range(0, 8)) - 4;
      GEN_RISING:  return k * 7 - 200;
      GEN_FALLING: return 300 - k * 5;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh80000000;
          1: return 32'sh7fffffff;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Offer one item and hold it until taken
  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic is_last);
    in_t it;
    it.value = v;
    it.last  = is_last;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Send batch_q, last marked on its final item, with random gaps unless back to back
  task automatic send_batch(input bit back_to_back);
    int n;
    foreach (batch_q[k]) begin
      send_item(batch_q[k], k == batch_q.size() - 1);
      n = back_to_back ? 0 : pick_gap();
      if (n > 0) begin
        item_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int size;
    int mode;
    int nbatch;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single item batch at the top of the range
    batch_q = '{32'sh7fffffff};
    send_batch(1'b0);
    // Range extremes mixed with zero and small values
    batch_q = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1};
    send_batch(1'b1);
    // Equal values must not count as inversions
    batch_q = '{3, 3, -2, 3, -2};
    send_batch(1'b0);
    // Strictly descending run
    batch_q = '{4, 3, 2, 1, 0, -1, -2};
    send_batch(1'b0);

    // Random batches: first a full descending one, then one past capacity
    nbatch = 0;
    while (items_sent < ITEM_TARGET) begin
      if (nbatch == 0) begin
        size = CAPACITY;
        mode = GEN_FALLING;
      end else if (nbatch == 1) begin
        size = CAPACITY + $urandom_range(1, 4);
        mode = GEN_RANDOM;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) size = CAPACITY + $urandom_range(1, 6);
        else if (r == 1) size = $urandom_range(33, CAPACITY);
        else if (r < 6) size = $urandom_range(9, 32);
        else size = $urandom_range(1, 8);
        mode = $urandom_range(GEN_RANDOM, GEN_EXTREME);
      end
      batch_q.delete();
      for (int k = 0; k < size; k++) batch_q = {batch_q, gen_value(mode, k)};
      send_batch($urandom_range(0, 3) == 0);
      nbatch++;
    end

    // Drain everything owed, then let the block settle
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("merge_sort_inversion_counter_top_tb: PASS");
    else $display("merge_sort_inversion_counter_top_tb: FAIL");
    $finish;
  end

  // Result back-pressure, with one long hold once 30 results have been seen
  initial begin
    bit held;
    int n;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      result_stall <= 1'b0;
      repeat (n) @(posedge clk);
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles with no item taken on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("merge_sort_inversion_counter_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
